@@ rtl/core/lwfs_pkg.sv @@
// lwfs_pkg: shared types, codes and constants of the wall-follow steering block
// no dependencies

package lwfs_pkg;

  localparam int RANGE_W = 16;
  localparam int ANGLE_W = 16;
  localparam int LIN_W   = 8;
  localparam int ANG_W   = 11;
  localparam int IDX_W   = 2;
  localparam int XW      = 36;
  localparam int ZW      = 34;
  localparam int PW      = 38;
  localparam int DIV_W   = 40;
  localparam int QW      = 11;
  localparam int QK_W    = 4;
  localparam int MAX_CORDIC = 24;
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = 2;
  localparam logic [15:0] GAIN_Q16 = 16'd39797;
  localparam logic OP_COMMAND = 1'b1;

  typedef enum logic [1:0] {
    CMD_RUN,
    CMD_STOP,
    CMD_TOGGLE
  } cmd_e;

  typedef enum logic [1:0] {
    REG_ANGLE_START,
    REG_ANGLE_STEP,
    REG_OFFSET_X,
    REG_OFFSET_Y
  } reg_e;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_ZERO,
    KIND_TWIST
  } kind_e;

  typedef enum logic [1:0] {
    TW_IDLE,
    TW_MUL,
    TW_SCALE,
    TW_DIV
  } tw_state_e;

  typedef struct packed {
    logic        [15:0] angle_start;
    logic signed [15:0] angle_step;
    logic signed [15:0] offset_x;
    logic signed [15:0] offset_y;
  } cfg_t;

  typedef struct packed {
    logic [RANGE_W-1:0] range_mm;
    logic [ANGLE_W-1:0] angle;
    logic               last;
    kind_e              kind;
  } entry_t;

  typedef struct packed {
    logic        left_seen;
    logic [15:0] left_far;
    logic        front_seen;
    logic [15:0] front_near;
  } track_t;

  typedef struct packed {
    logic busy;
    logic done;
  } tw_status_t;

  function automatic logic [31:0] atan_turn32(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'd536870912;
      5'd1:  r = 32'd316933406;
      5'd2:  r = 32'd167458907;
      5'd3:  r = 32'd85004756;
      5'd4:  r = 32'd42667331;
      5'd5:  r = 32'd21354465;
      5'd6:  r = 32'd10679838;
      5'd7:  r = 32'd5340245;
      5'd8:  r = 32'd2670163;
      5'd9:  r = 32'd1335087;
      5'd10: r = 32'd667544;
      5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;
      5'd13: r = 32'd83443;
      5'd14: r = 32'd41722;
      5'd15: r = 32'd20861;
      5'd16: r = 32'd10430;
      5'd17: r = 32'd5215;
      5'd18: r = 32'd2608;
      5'd19: r = 32'd1304;
      5'd20: r = 32'd652;
      5'd21: r = 32'd326;
      5'd22: r = 32'd163;
      5'd23: r = 32'd81;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/core/lwfs_if.sv @@
// lwfs channel interfaces: sample/command input, twist output, register write
// depends on nothing

interface lwfs_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [15:0] range_mm;
  logic        last_sample;
  logic [1:0]  command;
  modport source(output valid, op, range_mm, last_sample, command, input ready);
  modport sink(input valid, op, range_mm, last_sample, command, output ready);
endinterface

interface lwfs_out_if;
  logic               valid;
  logic               ready;
  logic [7:0]         linear_mm_s;
  logic signed [10:0] angular_mrad_s;
  modport source(output valid, linear_mm_s, angular_mrad_s, input ready);
  modport sink(input valid, linear_mm_s, angular_mrad_s, output ready);
endinterface

interface lwfs_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

@@ rtl/core/lwfs_queue.sv @@
// lwfs_queue: short queue of classified samples between front and back end
// depends on lwfs_pkg

module lwfs_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  lwfs_pkg::entry_t  entry_i,
  output logic              full_o,
  input  logic              pop_i,
  output lwfs_pkg::entry_t  entry_o,
  output logic              empty_o
);

  lwfs_pkg::entry_t mem_q [lwfs_pkg::QDEPTH];
  logic [lwfs_pkg::QPTR_W-1:0] wr_q, rd_q;
  logic [lwfs_pkg::QPTR_W:0]   cnt_q;

  assign full_o  = (cnt_q == (lwfs_pkg::QPTR_W+1)'(lwfs_pkg::QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign entry_o = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i) rd_q <= rd_q + 1'b1;
      if (push_i && !pop_i) cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= entry_i;
  end

endmodule

@@ rtl/core/lwfs_front.sv @@
// lwfs_front: accepts items, runs commands, sequences sample angles, tags scan end
// depends on lwfs_pkg and lwfs_if

module lwfs_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  lwfs_in_if.sink           in_i,
  input  lwfs_pkg::cfg_t    cfg_i,
  output logic              push_o,
  output lwfs_pkg::entry_t  entry_o,
  input  logic              full_i
);

  logic        paused_q, paused_d;
  logic        stopped_q, stopped_d;
  logic        in_scan_q, in_scan_d;
  logic [15:0] angle_now_q, angle_now_d;
  logic        accept;
  logic [15:0] a;

  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && !full_i;
  assign a          = in_scan_q ? angle_now_q : cfg_i.angle_start;

  always_comb begin
    paused_d      = paused_q;
    stopped_d     = stopped_q;
    in_scan_d     = in_scan_q;
    angle_now_d   = angle_now_q;
    push_o        = 1'b0;
    entry_o.range_mm = in_i.range_mm;
    entry_o.angle    = a;
    entry_o.last     = in_i.last_sample;
    entry_o.kind     = lwfs_pkg::KIND_NONE;
    if (accept) begin
      if (in_i.op == lwfs_pkg::OP_COMMAND) begin
        case (in_i.command)
          lwfs_pkg::CMD_RUN:    paused_d = 1'b0;
          lwfs_pkg::CMD_STOP:   paused_d = 1'b1;
          lwfs_pkg::CMD_TOGGLE: paused_d = !paused_q;
          default:              paused_d = paused_q;
        endcase
      end else begin
        push_o      = 1'b1;
        angle_now_d = a + cfg_i.angle_step;
        in_scan_d   = 1'b1;
        if (in_i.last_sample) begin
          in_scan_d = 1'b0;
          if (paused_q) begin
            entry_o.kind = stopped_q ? lwfs_pkg::KIND_NONE : lwfs_pkg::KIND_ZERO;
            stopped_d    = 1'b1;
          end else begin
            entry_o.kind = lwfs_pkg::KIND_TWIST;
            stopped_d    = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      paused_q    <= 1'b1;
      stopped_q   <= 1'b0;
      in_scan_q   <= 1'b0;
      angle_now_q <= '0;
    end else begin
      paused_q    <= paused_d;
      stopped_q   <= stopped_d;
      in_scan_q   <= in_scan_d;
      angle_now_q <= angle_now_d;
    end
  end

endmodule

@@ rtl/core/lwfs_twist.sv @@
// lwfs_twist: turns the scan trackers into a clipped twist, dividing by reciprocal multiply
// depends on lwfs_pkg

module lwfs_twist #(
  parameter int ROBOT_RADIUS_MM = 200,
  parameter int MIN_APPROACH_MM = 300,
  parameter int MAX_APPROACH_MM = 500
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  lwfs_pkg::track_t        trk_i,
  output lwfs_pkg::tw_status_t    status_o,
  output logic [7:0]              lin_o,
  output logic signed [10:0]      ang_o
);

  localparam int DRAW = MAX_APPROACH_MM - MIN_APPROACH_MM;
  localparam int D    = (DRAW < 1) ? 1 : DRAW;
  localparam int DEN  = 2 * ROBOT_RADIUS_MM * D;
  localparam int RSH  = 24;
  localparam logic [31:0] R_U   = 32'(ROBOT_RADIUS_MM);
  localparam logic [31:0] R2_U  = 32'(2 * ROBOT_RADIUS_MM);
  localparam logic [31:0] D_U   = 32'(D);
  localparam logic [31:0] MIN_U = 32'(MIN_APPROACH_MM);
  localparam logic [31:0] MAX_U = 32'(MAX_APPROACH_MM);
  localparam logic [31:0] RCA   = 32'((longint'(1000) << RSH) / longint'(DEN));
  localparam logic [31:0] RCL   = 32'((longint'(250) << RSH) / longint'(DEN));
  localparam logic [lwfs_pkg::DIV_W-1:0] DEN_U  = lwfs_pkg::DIV_W'(DEN);
  localparam logic [lwfs_pkg::DIV_W-1:0] DEN2_U = lwfs_pkg::DIV_W'(2 * DEN);

  lwfs_pkg::tw_state_e state_q, state_d;
  lwfs_pkg::track_t    trk_q, trk_d;
  logic [31:0] p1_q, p1_d, p2_q, p2_d, lp_q, lp_d;
  logic        neg_q, neg_d;
  logic [lwfs_pkg::DIV_W-1:0] na_q, na_d, nl_q, nl_d;
  logic [lwfs_pkg::QW-1:0]    qa_q, qa_d, ql_q, ql_d;
  logic [lwfs_pkg::QK_W-1:0]  k_q, k_d;
  logic [7:0]         lin_q, lin_d;
  logic signed [10:0] ang_q, ang_d;
  logic               done_q, done_d;

  logic [31:0] l32, f32, t1, d1, t2, d2, m;
  logic [63:0] ea, el;
  logic        sp_left, sp_front;

  assign status_o.busy = (state_q != lwfs_pkg::TW_IDLE) || done_q;
  assign status_o.done = done_q;
  assign lin_o = lin_q;
  assign ang_o = ang_q;

  always_comb begin
    l32 = 32'(trk_q.left_far);
    f32 = 32'(trk_q.front_near);
    t1  = (l32 >= R_U) ? 32'd0 : R_U - l32;
    d1  = (l32 >= R_U) ? R2_U : R_U + l32;
    t2  = 32'd0;
    d2  = D_U;
    if (trk_q.front_seen) begin
      t2 = (f32 >= MAX_U) ? 32'd0 : MAX_U - f32;
      if (t2 > D_U) t2 = D_U;
      d2 = (f32 <= MIN_U) ? 32'd0 : f32 - MIN_U;
      if (d2 > D_U) d2 = D_U;
    end
    m        = (p2_q > p1_q) ? p2_q - p1_q : p1_q - p2_q;
    ea       = m * RCA;
    el       = lp_q * RCL;
    sp_left  = !trk_q.left_seen;
    sp_front = trk_q.front_seen && (f32 <= MIN_U);
  end

  always_comb begin
    state_d = state_q;
    trk_d   = trk_q;
    p1_d = p1_q; p2_d = p2_q; lp_d = lp_q;
    neg_d = neg_q; na_d = na_q; nl_d = nl_q;
    qa_d = qa_q; ql_d = ql_q; k_d = k_q;
    lin_d = lin_q; ang_d = ang_q;
    done_d = 1'b0;
    unique case (state_q)
      lwfs_pkg::TW_IDLE: begin
        if (start_i) begin
          trk_d   = trk_i;
          state_d = lwfs_pkg::TW_MUL;
        end
      end
      lwfs_pkg::TW_MUL: begin
        p1_d    = t1[15:0] * D_U[15:0];
        p2_d    = t2[15:0] * R2_U[15:0];
        lp_d    = d1[15:0] * d2[15:0];
        state_d = lwfs_pkg::TW_SCALE;
      end
      lwfs_pkg::TW_SCALE: begin
        neg_d   = p2_q > p1_q;
        na_d    = lwfs_pkg::DIV_W'(m) * lwfs_pkg::DIV_W'(2000) + DEN_U;
        nl_d    = lwfs_pkg::DIV_W'(lp_q) * lwfs_pkg::DIV_W'(500) + DEN_U;
        qa_d    = lwfs_pkg::QW'(ea >> RSH);
        ql_d    = lwfs_pkg::QW'(el >> RSH);
        k_d     = lwfs_pkg::QK_W'(2);
        state_d = lwfs_pkg::TW_DIV;
      end
      lwfs_pkg::TW_DIV: begin
        // quotient estimate is low by at most two
        if (k_q == lwfs_pkg::QK_W'(2)) begin
          na_d = na_q - lwfs_pkg::DIV_W'(qa_q) * DEN2_U;
          nl_d = nl_q - lwfs_pkg::DIV_W'(ql_q) * DEN2_U;
        end else begin
          if (na_q >= DEN2_U) begin
            na_d = na_q - DEN2_U;
            qa_d = qa_q + 1'b1;
          end
          if (nl_q >= DEN2_U) begin
            nl_d = nl_q - DEN2_U;
            ql_d = ql_q + 1'b1;
          end
        end
        k_d = k_q - 1'b1;
        if (k_q == '0) begin
          state_d = lwfs_pkg::TW_IDLE;
          done_d  = 1'b1;
          if (sp_left) begin
            lin_d = '0;
            ang_d = 11'sd1000;
          end else if (sp_front) begin
            lin_d = '0;
            ang_d = -11'sd1000;
          end else begin
            lin_d = ql_d[7:0];
            ang_d = neg_q ? -$signed(qa_d) : $signed(qa_d);
          end
        end
      end
      default: state_d = lwfs_pkg::TW_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lwfs_pkg::TW_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    trk_q <= trk_d;
    p1_q <= p1_d; p2_q <= p2_d; lp_q <= lp_d;
    neg_q <= neg_d; na_q <= na_d; nl_q <= nl_d;
    qa_q <= qa_d; ql_q <= ql_d; k_q <= k_d;
    lin_q <= lin_d; ang_q <= ang_d;
  end

endmodule

@@ rtl/core/lwfs_back.sv @@
// lwfs_back: pipelined cordic, robot-frame offset, window trackers, output register
// depends on lwfs_pkg, lwfs_if and lwfs_twist

module lwfs_back #(
  parameter int CORDIC_STEPS    = 16,
  parameter int ROBOT_RADIUS_MM = 200,
  parameter int MIN_APPROACH_MM = 300,
  parameter int MAX_APPROACH_MM = 500
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lwfs_pkg::cfg_t    cfg_i,
  output logic              pop_o,
  input  lwfs_pkg::entry_t  entry_i,
  input  logic              empty_i,
  lwfs_out_if.source        out_o
);

  localparam int N  = (CORDIC_STEPS > lwfs_pkg::MAX_CORDIC) ? lwfs_pkg::MAX_CORDIC
                                                             : CORDIC_STEPS;
  localparam int XW = lwfs_pkg::XW;
  localparam int ZW = lwfs_pkg::ZW;
  localparam int PW = lwfs_pkg::PW;
  localparam logic signed [PW-1:0] FAR = PW'(MAX_APPROACH_MM * 65536);
  localparam logic signed [PW-1:0] RAD = PW'(ROBOT_RADIUS_MM * 65536);

  logic                 v_q   [0:N];
  logic signed [XW-1:0] x_q   [0:N];
  logic signed [XW-1:0] y_q   [0:N];
  logic signed [ZW-1:0] z_q   [0:N];
  logic                 l_q   [0:N];
  lwfs_pkg::kind_e      k_q   [0:N];

  logic                 pv_q;
  logic signed [PW-1:0] px_q, py_q;
  logic                 pl_q;
  lwfs_pkg::kind_e      pk_q;

  lwfs_pkg::track_t     trk_q, trk_n;
  lwfs_pkg::tw_status_t tw_st;
  logic [7:0]           tw_lin;
  logic signed [10:0]   tw_ang;

  logic                 out_valid_q;
  logic [7:0]           lin_q;
  logic signed [10:0]   ang_q;

  logic adv, end_scan, tw_start, zero_out;
  logic [31:0] prod;
  logic        mid;
  logic [15:0] z16;
  logic signed [XW-1:0] x0;
  logic signed [PW-1:0] ax, ay, ry, rx;

  assign adv   = !tw_st.busy && (!out_valid_q || out_o.ready);
  assign pop_o = adv && !empty_i;

  assign prod = 32'(entry_i.range_mm) * 32'(lwfs_pkg::GAIN_Q16);
  assign mid  = entry_i.angle[15] ^ entry_i.angle[14];
  assign z16  = mid ? (entry_i.angle ^ 16'h8000) : entry_i.angle;
  assign x0   = mid ? -$signed({{(XW-32){1'b0}}, prod}) : $signed({{(XW-32){1'b0}}, prod});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q[0] <= 1'b0;
    else if (adv) v_q[0] <= !empty_i;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      x_q[0] <= x0;
      y_q[0] <= '0;
      z_q[0] <= $signed({{(ZW-32){z16[15]}}, z16, 16'b0});
      l_q[0] <= entry_i.last;
      k_q[0] <= entry_i.kind;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_rot
    logic [31:0] at;
    assign at = lwfs_pkg::atan_turn32(5'(i));
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) v_q[i+1] <= 1'b0;
      else if (adv) v_q[i+1] <= v_q[i];
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        if (!z_q[i][ZW-1]) begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - $signed({{(ZW-32){1'b0}}, at});
        end else begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + $signed({{(ZW-32){1'b0}}, at});
        end
        l_q[i+1] <= l_q[i];
        k_q[i+1] <= k_q[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) pv_q <= 1'b0;
    else if (adv) pv_q <= v_q[N];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      px_q <= PW'(x_q[N]) + $signed({{(PW-32){cfg_i.offset_x[15]}}, cfg_i.offset_x, 16'b0});
      py_q <= PW'(y_q[N]) + $signed({{(PW-32){cfg_i.offset_y[15]}}, cfg_i.offset_y, 16'b0});
      pl_q <= l_q[N];
      pk_q <= k_q[N];
    end
  end

  always_comb begin
    ax = px_q[PW-1] ? -px_q : px_q;
    ay = py_q[PW-1] ? -py_q : py_q;
    ry = py_q + PW'(32768);
    rx = px_q + PW'(32768);
    trk_n = trk_q;
    if (!py_q[PW-1] && (py_q != '0) && (py_q <= FAR) && (ax <= RAD)) begin
      if (!trk_q.left_seen || (ry[31:16] > trk_q.left_far)) begin
        trk_n.left_far  = ry[31:16];
        trk_n.left_seen = 1'b1;
      end
    end
    if (!px_q[PW-1] && (px_q != '0) && (px_q <= FAR) && (ay <= RAD)) begin
      if (!trk_q.front_seen || (rx[31:16] < trk_q.front_near)) begin
        trk_n.front_near = rx[31:16];
        trk_n.front_seen = 1'b1;
      end
    end
  end

  assign end_scan = adv && pv_q && pl_q;
  assign tw_start = end_scan && (pk_q == lwfs_pkg::KIND_TWIST);
  assign zero_out = end_scan && (pk_q == lwfs_pkg::KIND_ZERO);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trk_q <= '0;
    end else if (adv && pv_q) begin
      trk_q <= pl_q ? '0 : trk_n;
    end
  end

  lwfs_twist #(
    .ROBOT_RADIUS_MM(ROBOT_RADIUS_MM),
    .MIN_APPROACH_MM(MIN_APPROACH_MM),
    .MAX_APPROACH_MM(MAX_APPROACH_MM)
  ) u_twist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (tw_start),
    .trk_i   (trk_n),
    .status_o(tw_st),
    .lin_o   (tw_lin),
    .ang_o   (tw_ang)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (zero_out || tw_st.done) out_valid_q <= 1'b1;
    else if (out_o.ready) out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (zero_out) begin
      lin_q <= '0;
      ang_q <= '0;
    end else if (tw_st.done) begin
      lin_q <= tw_lin;
      ang_q <= tw_ang;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.linear_mm_s    = lin_q;
  assign out_o.angular_mrad_s = ang_q;

endmodule

@@ rtl/core/lidar_wall_follow_steer.sv @@
// Wall-follow steering from planar laser scans. One sample or command is taken per
// cycle while the queue is not full; a sample's point leaves a CORDIC pipeline of
// CORDIC_STEPS stages (at most MAX_CORDIC) and reaches the trackers via the input,
// rotation and offset registers. At each running scan end the back end stalls
// while the twist unit forms its products and divides by reciprocal multiplication
// with two correction steps; the front end keeps filling its 4-entry queue.
// Depends on lwfs_pkg, lwfs_if, lwfs_queue, lwfs_front and lwfs_back.

module lidar_wall_follow_steer #(
  parameter int CORDIC_STEPS    = 16,
  parameter int ROBOT_RADIUS_MM = 200,
  parameter int MIN_APPROACH_MM = 300,
  parameter int MAX_APPROACH_MM = 500
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lwfs_in_if.sink     in_i,
  lwfs_cfg_if.sink    cfg_i,
  lwfs_out_if.source  out_o
);

  lwfs_pkg::cfg_t   cfg_q;
  lwfs_pkg::entry_t push_entry, pop_entry;
  logic push, pop, full, empty;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        lwfs_pkg::REG_ANGLE_START: cfg_q.angle_start <= cfg_i.data;
        lwfs_pkg::REG_ANGLE_STEP:  cfg_q.angle_step  <= $signed(cfg_i.data);
        lwfs_pkg::REG_OFFSET_X:    cfg_q.offset_x    <= $signed(cfg_i.data);
        lwfs_pkg::REG_OFFSET_Y:    cfg_q.offset_y    <= $signed(cfg_i.data);
        default:                   cfg_q             <= cfg_q;
      endcase
    end
  end

  lwfs_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .cfg_i  (cfg_q),
    .push_o (push),
    .entry_o(push_entry),
    .full_i (full)
  );

  lwfs_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .entry_i(push_entry),
    .full_o (full),
    .pop_i  (pop),
    .entry_o(pop_entry),
    .empty_o(empty)
  );

  lwfs_back #(
    .CORDIC_STEPS   (CORDIC_STEPS),
    .ROBOT_RADIUS_MM(ROBOT_RADIUS_MM),
    .MIN_APPROACH_MM(MIN_APPROACH_MM),
    .MAX_APPROACH_MM(MAX_APPROACH_MM)
  ) u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .pop_o  (pop),
    .entry_i(pop_entry),
    .empty_i(empty),
    .out_o  (out_o)
  );

endmodule

@@ verif/tb_top.sv @@
// tb_top: self-checking testbench of lidar_wall_follow_steer with a scan-level twist predictor
// depends on lwfs_pkg, lwfs_if and the rtl top level
`timescale 1ns / 1ps

module tb_top;

  localparam int STEPS   = 16;
  localparam int RAD_MM  = 200;
  localparam int MIN_MM  = 300;
  localparam int MAX_MM  = 500;
  localparam int SETTLE  = 80;

  typedef struct {
    bit        op;
    bit [15:0] range_mm;
    bit        last;
    bit [1:0]  command;
  } item_t;

  typedef struct {
    bit [7:0]         lin;
    bit signed [10:0] ang;
  } twist_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  lwfs_in_if  in_if();
  lwfs_out_if out_if();
  lwfs_cfg_if cfg_if();

  lidar_wall_follow_steer i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .cfg_i (cfg_if),
    .out_o (out_if)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  item_t  pend_q[$];
  twist_t twist_q[$];
  item_t  cur_item;
  bit     in_took;
  int     src_idle;
  int     snk_stall;
  int     stall_left;
  int     errs;

  // steering state mirror
  bit [15:0]   c_start;
  bit [15:0]   c_step;
  longint      c_offx, c_offy;
  bit          paused, stopped, in_scan;
  bit [15:0]   angle_now;
  longint      left_far, front_near;
  bit          left_seen, front_seen;

  longint atan_lut[16] = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                           10679838, 5340245, 2670163, 1335087, 667544, 333772,
                           166886, 83443, 41722, 20861};

  function automatic longint clampl(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint div_round(longint num, longint den);
    if (num >= 0) return (2 * num + den) / (2 * den);
    return -((-2 * num + den) / (2 * den));
  endfunction

  function automatic void clear_trackers();
    left_far = 0;
    left_seen = 0;
    front_near = 0;
    front_seen = 0;
    in_scan = 0;
  endfunction

  function automatic twist_t steer_twist();
    twist_t t;
    longint d, lin, ang, t1, d1, t2, d2;
    d = MAX_MM - MIN_MM;
    if (d < 1) d = 1;
    lin = 0;
    if (!left_seen) begin
      ang = 1000;
    end else if (front_seen && front_near <= MIN_MM) begin
      ang = -1000;
    end else begin
      t1 = clampl(RAD_MM - left_far, 0, 2 * RAD_MM);
      d1 = clampl(RAD_MM + left_far, 0, 2 * RAD_MM);
      t2 = front_seen ? clampl(MAX_MM - front_near, 0, d) : 0;
      d2 = front_seen ? clampl(front_near - MIN_MM, 0, d) : d;
      ang = div_round(1000 * (t1 * d - t2 * 2 * RAD_MM), 2 * RAD_MM * d);
      lin = div_round(250 * d1 * d2, 2 * RAD_MM * d);
    end
    t.ang = 11'(clampl(ang, -1000, 1000));
    t.lin = 8'(clampl(lin, 0, 250));
    return t;
  endfunction

  function automatic void track_point(item_t it);
    longint x, y, z, dx, dy, px, py, ax, ay, mm;
    longint rad, far;
    bit [15:0] a;
    rad = longint'(RAD_MM) * 65536;
    far = longint'(MAX_MM) * 65536;
    if (!in_scan) angle_now = c_start;
    a = angle_now;
    x = longint'(it.range_mm) * longint'(lwfs_pkg::GAIN_Q16);
    y = 0;
    if (a >= 16384 && a < 49152) begin
      x = -x;
      z = longint'(a) - 32768;
    end else begin
      z = a >= 49152 ? longint'(a) - 65536 : longint'(a);
    end
    z = z * 65536;
    for (int i = 0; i < STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_lut[i];
      end else begin
        x += dx; y -= dy; z += atan_lut[i];
      end
    end
    px = x + c_offx * 65536;
    py = y + c_offy * 65536;
    ax = px < 0 ? -px : px;
    ay = py < 0 ? -py : py;
    if (py > 0 && py <= far && ax <= rad) begin
      mm = ((py + 32768) >>> 16) & 16'hFFFF;
      if (!left_seen || mm > left_far) begin
        left_far = mm;
        left_seen = 1;
      end
    end
    if (px > 0 && px <= far && ay <= rad) begin
      mm = ((px + 32768) >>> 16) & 16'hFFFF;
      if (!front_seen || mm < front_near) begin
        front_near = mm;
        front_seen = 1;
      end
    end
    angle_now = a + c_step;
    in_scan = 1;
  endfunction

  function automatic void predict_item(item_t it);
    twist_t t;
    if (it.op == lwfs_pkg::OP_COMMAND) begin
      case (lwfs_pkg::cmd_e'(it.command))
        lwfs_pkg::CMD_RUN:    paused = 0;
        lwfs_pkg::CMD_STOP:   paused = 1;
        lwfs_pkg::CMD_TOGGLE: paused = !paused;
        default: ;
      endcase
      return;
    end
    track_point(it);
    if (!it.last) return;
    if (paused) begin
      clear_trackers();
      if (!stopped) begin
        stopped = 1;
        t.lin = '0;
        t.ang = '0;
        twist_q.push_back(t);
      end
    end else begin
      twist_q.push_back(steer_twist());
      stopped = 0;
      clear_trackers();
    end
  endfunction

  // input transfers and output checks
  always @(posedge clk_i) begin
    if (rst_ni && in_if.valid && in_if.ready) begin
      predict_item(cur_item);
      in_took = 1;
    end
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (twist_q.size() == 0) begin
        errs++;
        if (errs <= 10) $display("unexpected twist lin=%0d ang=%0d",
                                 out_if.linear_mm_s, out_if.angular_mrad_s);
      end else begin
        twist_t t;
        t = twist_q.pop_front();
        if (t.lin !== out_if.linear_mm_s || t.ang !== out_if.angular_mrad_s) begin
          errs++;
          if (errs <= 10) $display("twist mismatch: exp lin=%0d ang=%0d got lin=%0d ang=%0d",
                                   t.lin, t.ang, out_if.linear_mm_s, out_if.angular_mrad_s);
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk_i) begin
    if (stall_left > 0) stall_left--;
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      out_if.ready <= 1'b0;
    end else begin
      if (!in_if.valid || in_took) begin
        in_took = 0;
        if (pend_q.size() > 0 && $urandom_range(99) >= src_idle) begin
          cur_item = pend_q.pop_front();
          in_if.valid <= 1'b1;
          in_if.op <= cur_item.op;
          in_if.range_mm <= cur_item.range_mm;
          in_if.last_sample <= cur_item.last;
          in_if.command <= cur_item.command;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
      out_if.ready <= (stall_left == 0) && ($urandom_range(99) >= snk_stall);
    end
  end

  task automatic write_reg(lwfs_pkg::reg_e idx, bit [15:0] val);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    case (idx)
      lwfs_pkg::REG_ANGLE_START: c_start = val;
      lwfs_pkg::REG_ANGLE_STEP:  c_step = val;
      lwfs_pkg::REG_OFFSET_X:    c_offx = longint'($signed(val));
      lwfs_pkg::REG_OFFSET_Y:    c_offy = longint'($signed(val));
    endcase
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic set_regs(bit [15:0] st, bit [15:0] sp, bit [15:0] ox, bit [15:0] oy);
    write_reg(lwfs_pkg::REG_ANGLE_START, st);
    write_reg(lwfs_pkg::REG_ANGLE_STEP, sp);
    write_reg(lwfs_pkg::REG_OFFSET_X, ox);
    write_reg(lwfs_pkg::REG_OFFSET_Y, oy);
  endtask

  task automatic add_cmd(lwfs_pkg::cmd_e c);
    item_t it;
    it.op = lwfs_pkg::OP_COMMAND;
    it.range_mm = 16'($urandom);
    it.last = 1'($urandom);
    it.command = c;
    pend_q.push_back(it);
  endtask

  task automatic add_sample(bit [15:0] r, bit l);
    item_t it;
    it.op = 1'b0;
    it.range_mm = r;
    it.last = l;
    it.command = 2'($urandom);
    pend_q.push_back(it);
  endtask

  task automatic drain();
    do @(posedge clk_i); while (pend_q.size() != 0 || in_if.valid || twist_q.size() != 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // mostly well-formed scans, some noise commands
  task automatic add_random(int n);
    int len, k;
    bit [15:0] r;
    k = 0;
    while (k < n) begin
      if ($urandom_range(9) == 0) begin
        item_t it;
        it.op = lwfs_pkg::OP_COMMAND;
        it.range_mm = 16'($urandom);
        it.last = 1'($urandom);
        it.command = $urandom_range(9) < 6 ? lwfs_pkg::CMD_RUN : 2'($urandom);
        pend_q.push_back(it);
        k++;
      end else begin
        len = $urandom_range(1, 12);
        for (int j = 0; j < len; j++) begin
          case ($urandom_range(9))
            0:       r = 16'($urandom);
            1:       r = $urandom_range(1) ? 16'hFFFF : 16'h0000;
            default: r = 16'($urandom_range(0, 800));
          endcase
          add_sample(r, (j == len - 1) ? 1'b1 : ($urandom_range(29) == 0));
        end
        k += len;
      end
    end
  endtask

  initial begin
    in_if.valid = 1'b0;
    in_if.op = 1'b0;
    in_if.range_mm = '0;
    in_if.last_sample = 1'b0;
    in_if.command = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    in_took = 0;
    src_idle = 0;
    snk_stall = 0;
    stall_left = 0;
    errs = 0;
    c_start = 0;
    c_step = 0;
    c_offx = 0;
    c_offy = 0;
    paused = 1;
    stopped = 0;
    angle_now = 0;
    clear_trackers();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: paused scans, commands, field extremes
    set_regs(16'd49152, 16'd4096, 16'd0, 16'd0);
    add_sample(16'd0, 1'b1);
    add_sample(16'd300, 1'b1);
    add_cmd(lwfs_pkg::CMD_TOGGLE);
    add_sample(16'hFFFF, 1'b0);
    add_sample(16'd250, 1'b1);
    pend_q.push_back('{op: 1'b1, range_mm: 16'h0, last: 1'b0, command: 2'd3});
    add_cmd(lwfs_pkg::CMD_STOP);
    add_sample(16'd100, 1'b1);
    add_cmd(lwfs_pkg::CMD_RUN);
    for (int j = 0; j < 9; j++) add_sample(16'(j * 60), j == 8);
    add_sample(16'd0, 1'b1);
    add_sample(16'hFFFF, 1'b1);
    add_cmd(lwfs_pkg::CMD_TOGGLE);
    add_cmd(lwfs_pkg::CMD_TOGGLE);
    drain();

    // random phases: idling pattern and register settings change per phase
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin src_idle = 0;  snk_stall = 0;  set_regs(16'hFFFF, 16'h8000, 16'h7FFF, 16'h8000); end
        1: begin src_idle = 63; snk_stall = 0;  set_regs(16'd0, 16'h7FFF, 16'h8000, 16'h7FFF); end
        2: begin src_idle = 0;  snk_stall = 63; set_regs(16'd49152, 16'd5461, 16'd50, 16'hFFCE); end
        default: begin
          src_idle = 8; snk_stall = 8;
          set_regs(16'($urandom_range(45000, 53000)), 16'($urandom_range(2000, 8000)),
                   16'($signed($urandom_range(0, 200)) - 100), 16'($urandom));
        end
      endcase
      add_cmd(lwfs_pkg::CMD_RUN);
      if (ph == 2) stall_left = 400;
      add_random(500);
      drain();
    end

    if (errs == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #4ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
